// ===== sv/spitad_pkg.sv =====
// ----------------------------------------------------------------------------
// spitad_pkg
// shared types, constants and the byte bit-reverse for the spi target core
// ----------------------------------------------------------------------------
package spitad_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BIT_CNT_W  = 5;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 24;

    // bit counter landmarks
    localparam logic [BIT_CNT_W-1:0] ADDR_LAST_BIT = 5'd7;
    localparam logic [BIT_CNT_W-1:0] DATA_FIRST_BIT = 5'd8;
    localparam logic [BIT_CNT_W-1:0] FRAME_END_BIT = 5'd16;
    localparam logic [POS_W-1:0]     BYTE_POS_END  = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_USED = 1'b1;

    typedef struct packed {
        logic              clk_pin;
        logic              sdi_pin;
        logic              select_pin;
        logic [BYTE_W-1:0] tx_byte;
    } t_sample;

    typedef struct packed {
        logic              cipo_level;
        logic              tx_pop;
        logic              address_valid;
        logic [BYTE_W-1:0] address_byte;
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
    } t_result;

    typedef struct packed {
        logic msb_first;
        logic select_used;
    } t_cfg;

    // swap nibbles, then bit pairs, then single bits
    function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] c;
        a = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
        b = ((a & 8'hCC) >> 2) | ((a & 8'h33) << 2);
        c = ((b & 8'hAA) >> 1) | ((b & 8'h55) << 1);
        return c;
    endfunction

endpackage

// ===== sv/spi_target_addr_data_frame_core.sv =====
// ----------------------------------------------------------------------------
// spi_target_addr_data_frame_core
// mode 0 spi target: address byte then data byte per frame, one pin sample
// per beat, one result beat per sample
// ----------------------------------------------------------------------------
//
//  channel   direction  ports                      beat contents
//  --------  ---------  -------------------------  ------------------------------
//  sample    in         i_s_tvalid/o_s_tready      pin sample + transmit head
//  result    out        o_m_tvalid/i_m_tready      cipo level, pop, bytes, flags
//  config    in         i_cfg_valid/o_cfg_ready    register index + write data
//
//  one sample beat is accepted every cycle while the result side keeps up;
//  each beat passes an input register and then a result register between
//  acceptance and result.
//  a stalled result side holds the result register and then the input
//  register; the sample ready drops only when both are full.
//  reset (synchronous, active low) clears the frame state, msb_first to 0
//  and select_used to 1; the config port is always ready.
// ----------------------------------------------------------------------------
module spi_target_addr_data_frame_core
    import spitad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // sample channel
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [0] clk_pin, [1] sdi_pin, [2] select_pin, [10:3] tx_byte, [15:11] zero
    input  logic [S_TDATA_W-1:0]  i_s_tdata,

    // result channel
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] cipo_level, [1] tx_pop, [9:2] address_byte, [17:10] data_byte,
    // [23:18] zero
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // [0] address_valid
    output logic                  o_m_tuser,
    // data_valid: frame ended on this sample
    output logic                  o_m_tlast,

    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                  i_cfg_data
);

    // input register stage
    logic    r_in_valid;
    t_sample r_in_sample;

    // result register stage
    logic    r_out_valid;
    t_result r_out;

    // configuration registers
    t_cfg r_cfg;

    logic                 out_free;
    logic                 advance;
    t_result              step_result;
    logic [BIT_CNT_W-1:0] bit_count;

    // the result register frees up when empty or being drained this cycle
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // sample fields unpacked from the low bits of the beat
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_sample.clk_pin    <= i_s_tdata[0];
            r_in_sample.sdi_pin    <= i_s_tdata[1];
            r_in_sample.select_pin <= i_s_tdata[2];
            r_in_sample.tx_byte    <= i_s_tdata[10:3];
        end
    end

    // frame state steps exactly once per sample, when it moves to the result
    spitad_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_sample    (r_in_sample),
        .i_cfg       (r_cfg),
        .o_result    (step_result),
        .o_bit_count (bit_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.data_byte, r_out.address_byte,
                         r_out.tx_pop, r_out.cipo_level};
    assign o_m_tuser  = r_out.address_valid;
    assign o_m_tlast  = r_out.data_valid;

    // config writes land immediately
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.msb_first   <= 1'b0;
            r_cfg.select_used <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MSB_FIRST:   r_cfg.msb_first   <= i_cfg_data;
                CFG_SELECT_USED: r_cfg.select_used <= i_cfg_data;
            endcase
        end
    end

    // bit counter never passes the frame end
    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bit_count <= FRAME_END_BIT)
        else $error("bit counter beyond frame end");

    // address and frame end cannot complete on the same sample
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser && o_m_tlast))
        else $error("address and data reported together");

    // a beat leaving the input register always lands in the result register
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("sample lost between stages");

    // byte fields read zero when their flag is low
    a_zero_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.data_valid |-> r_out.data_byte == '0)
        else $error("data byte set without frame end");

endmodule

// ===== sv/spitad_frame.sv =====
// ----------------------------------------------------------------------------
// spitad_frame
// frame state and per-sample step: edge detect, shift, transmit bit drive
// ----------------------------------------------------------------------------
module spitad_frame
    import spitad_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output t_result o_result,
    output logic [BIT_CNT_W-1:0] o_bit_count
);

    logic                 r_last_clock, n_last_clock;
    logic [BIT_CNT_W-1:0] r_bit_count, n_bit_count;
    logic [BYTE_W-1:0]    r_addr_shift, n_addr_shift;
    logic [BYTE_W-1:0]    r_data_shift, n_data_shift;
    logic [BYTE_W-1:0]    r_send_byte, n_send_byte;
    logic                 r_send_loaded, n_send_loaded;
    logic                 r_out_level, n_out_level;

    logic             act;
    logic             data_phase;
    logic [POS_W-1:0] pos;
    t_result          res;

    always_comb begin
        n_last_clock  = r_last_clock;
        n_bit_count   = r_bit_count;
        n_addr_shift  = r_addr_shift;
        n_data_shift  = r_data_shift;
        n_send_byte   = r_send_byte;
        n_send_loaded = r_send_loaded;
        n_out_level   = r_out_level;
        res           = '0;

        data_phase = (r_bit_count >= DATA_FIRST_BIT);
        pos = data_phase ? POS_W'(r_bit_count - DATA_FIRST_BIT) : POS_W'(r_bit_count);

        // idle low clock, deselected, or no clock edge: sample ignored
        act = 1'b1;
        if (!i_sample.clk_pin && (r_bit_count == '0)) begin
            act = 1'b0;
        end else if (i_cfg.select_used && !i_sample.select_pin) begin
            act = 1'b0;
        end else if (r_last_clock == i_sample.clk_pin) begin
            act = 1'b0;
        end

        if (act) begin
            n_last_clock = i_sample.clk_pin;

            // pop the transmit byte once the data phase starts
            if (!r_send_loaded && data_phase) begin
                n_send_byte   = i_cfg.msb_first ? flip8(i_sample.tx_byte)
                                                : i_sample.tx_byte;
                n_send_loaded = 1'b1;
                res.tx_pop    = 1'b1;
            end

            if (i_sample.clk_pin) begin
                if (pos < BYTE_POS_END) begin
                    if (!data_phase) begin
                        n_addr_shift[pos[2:0]] = i_sample.sdi_pin;
                    end else begin
                        n_data_shift[pos[2:0]] = i_sample.sdi_pin;
                    end
                end
            end else if (n_send_loaded && data_phase) begin
                n_out_level = (pos < BYTE_POS_END) ? n_send_byte[pos[2:0]] : 1'b0;
            end

            if (i_sample.clk_pin && (r_bit_count == ADDR_LAST_BIT)) begin
                if (i_cfg.msb_first) begin
                    n_addr_shift = flip8(n_addr_shift);
                end
                res.address_valid = 1'b1;
                res.address_byte  = n_addr_shift;
            end

            if (r_bit_count >= FRAME_END_BIT) begin
                n_bit_count   = '0;
                n_send_byte   = '0;
                n_send_loaded = 1'b0;
                if (i_cfg.msb_first) begin
                    n_data_shift = flip8(n_data_shift);
                end
                res.data_valid = 1'b1;
                res.data_byte  = n_data_shift;
                n_out_level    = 1'b0;
            end else if (i_sample.clk_pin) begin
                n_bit_count = r_bit_count + 1'b1;
            end
        end

        res.cipo_level = n_out_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_clock  <= 1'b0;
            r_bit_count   <= '0;
            r_addr_shift  <= '0;
            r_data_shift  <= '0;
            r_send_byte   <= '0;
            r_send_loaded <= 1'b0;
            r_out_level   <= 1'b0;
        end else if (i_step) begin
            r_last_clock  <= n_last_clock;
            r_bit_count   <= n_bit_count;
            r_addr_shift  <= n_addr_shift;
            r_data_shift  <= n_data_shift;
            r_send_byte   <= n_send_byte;
            r_send_loaded <= n_send_loaded;
            r_out_level   <= n_out_level;
        end
    end

    assign o_result    = res;
    assign o_bit_count = r_bit_count;

endmodule
